### design/vcsp_pkg.sv
// Shared types, constants and helper functions of the voxel chunk stream parser.
// Used by the channel interfaces, the controller, the datapath and the top level.
package vcsp_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = 11;
   localparam int DIM_W   = 9;
   localparam int MID_W   = 17;
   localparam int GI_W    = 25;
   localparam int SLOT_W  = 8;

   // Largest grid dimension a SIZE chunk may declare
   localparam logic [WORD_W-1:0] MAX_DIM = 32'd256;

   // Chunk and magic tags, first file byte in bits 7..0
   localparam logic [WORD_W-1:0] TAG_VOX  = 32'h2058_4F56;
   localparam logic [WORD_W-1:0] TAG_MAIN = 32'h4E49_414D;
   localparam logic [WORD_W-1:0] TAG_SIZE = 32'h455A_4953;
   localparam logic [WORD_W-1:0] TAG_XYZI = 32'h495A_5958;
   localparam logic [WORD_W-1:0] TAG_RGBA = 32'h4142_4752;

   // Byte counts of headers and bodies
   localparam logic [WORD_W-1:0] HDR_BYTES  = 32'd12;
   localparam logic [WORD_W-1:0] SIZE_BYTES = 32'd12;
   localparam logic [WORD_W-1:0] XYZI_MIN   = 32'd4;
   localparam logic [WORD_W-1:0] PAL_BYTES  = 32'd1024;

   // Result kinds
   typedef enum logic [2:0] {
      K_SIZES   = 3'd0,
      K_CLEAR   = 3'd1,
      K_WRITE   = 3'd2,
      K_PALETTE = 3'd3,
      K_OK      = 3'd4,
      K_ERROR   = 3'd5
   } kind_type;

   // Parse phases
   typedef enum logic [3:0] {
      PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_HDR, PH_MAIN_SKIP, PH_CHUNK_HDR,
      PH_SIZE, PH_XCOUNT, PH_XREC, PH_RGBA, PH_SKIPC, PH_SKIPK, PH_DONE, PH_DEAD
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      C_IDLE, C_MUL1, C_MUL2, C_OUT_PARSE, C_OUT_STATUS
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic step;
      logic mul1;
      logic mul2;
      logic sel_status;
      logic clear;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic par;
      logic mul;
      logic last;
      logic pend_last;
   } dp_stat_type;

   // Count down, stopping at zero
   function automatic logic [WORD_W-1:0] sat_dec(logic [WORD_W-1:0] v);
      return (v != '0) ? v - 32'd1 : v;
   endfunction

   // Start the next child chunk if a full header still fits in the region
   function automatic phase_type chunk_start(logic [WORD_W-1:0] main_left);
      return (main_left >= HDR_BYTES) ? PH_CHUNK_HDR : PH_DONE;
   endfunction

   // Skip leftover content, then sub-chunks, then move on
   function automatic phase_type fin_content(logic [WORD_W-1:0] content_left,
                                             logic [WORD_W-1:0] children_left,
                                             logic [WORD_W-1:0] main_left);
      phase_type ph;
      if (content_left != '0) begin
         ph = PH_SKIPC;
      end else if (children_left != '0) begin
         ph = PH_SKIPK;
      end else begin
         ph = chunk_start(main_left);
      end
      return ph;
   endfunction

endpackage

### design/vcsp_if.sv
// Valid/ready channel interfaces for file bytes in and parse results out.
// Depends on vcsp_pkg for field widths and the result kind type.
interface vcsp_req_if import vcsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_req;
   logic              last;

   modport source (output valid, output byte_req, output last, input ready);
   modport sink   (input valid, input byte_req, input last, output ready);
endinterface

interface vcsp_rsp_if import vcsp_pkg::*; ();
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [GI_W-1:0]   grid_index;
   logic [WORD_W-1:0] color;
   logic [SLOT_W-1:0] palette_index;
   logic [DIM_W-1:0]  size_x;
   logic [DIM_W-1:0]  size_y;
   logic [DIM_W-1:0]  size_z;
   logic              palette_seen;
   logic              end_of_run;

   modport source (output valid, output kind, output grid_index, output color,
                   output palette_index, output size_x, output size_y, output size_z,
                   output palette_seen, output end_of_run, input ready);
   modport sink   (input valid, input kind, input grid_index, input color,
                   input palette_index, input size_x, input size_y, input size_z,
                   input palette_seen, input end_of_run, output ready);
endinterface

### design/vox_chunk_stream_parser_unit.sv
// Voxel chunk stream parser: one file byte a beat in, grid and palette results out.
// Each byte is registered on accept; a sizes or palette beat shows in the cycle after accept,
// a grid clear or voxel write after its two registered multiply stages; a status beat comes
// in the cycle after accept, or in the cycle after the parse beat of the same byte is taken.
// Throughput: one byte per cycle for silent bytes; a byte with results holds the input
// until its beats are taken, multiply passes and status beat included. Synchronous
// active-high reset returns the parser to the magic check; it also returns there after
// each final status beat.
module vox_chunk_stream_parser_unit import vcsp_pkg::*; #(
   parameter logic [WORD_W-1:0] MAX_DIM = vcsp_pkg::MAX_DIM
) (
   input logic          clock,
   input logic          reset,
   vcsp_req_if.sink     req_bus,
   vcsp_rsp_if.source   rsp_bus
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer
   vcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Parse datapath
   vcsp_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_byte          (req_bus.byte_req),
      .req_last          (req_bus.last),
      .rsp_kind          (rsp_bus.kind),
      .rsp_grid_index    (rsp_bus.grid_index),
      .rsp_color         (rsp_bus.color),
      .rsp_palette_index (rsp_bus.palette_index),
      .rsp_size_x        (rsp_bus.size_x),
      .rsp_size_y        (rsp_bus.size_y),
      .rsp_size_z        (rsp_bus.size_z),
      .rsp_palette_seen  (rsp_bus.palette_seen),
      .rsp_end_of_run    (rsp_bus.end_of_run)
   );

endmodule

### design/vcsp_ctrl.sv
// Sequencing state machine: byte accept, two multiply passes, result beats.
// Depends on vcsp_pkg for the state, command and status types.
module vcsp_ctrl import vcsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE: begin
            if (req_valid) begin
               if (stat.mul) begin
                  state_in = C_MUL1;
               end else if (stat.par) begin
                  state_in = C_OUT_PARSE;
               end else if (stat.last) begin
                  state_in = C_OUT_STATUS;
               end
            end
         end
         C_MUL1: state_in = C_MUL2;
         C_MUL2: state_in = C_OUT_PARSE;
         C_OUT_PARSE: begin
            if (rsp_ready) begin
               state_in = stat.pend_last ? C_OUT_STATUS : C_IDLE;
            end
         end
         C_OUT_STATUS: begin
            if (rsp_ready) begin
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   // Handshake and datapath commands
   always_comb begin
      req_ready      = (state_ff == C_IDLE);
      rsp_valid      = (state_ff == C_OUT_PARSE) || (state_ff == C_OUT_STATUS);
      cmd.step       = (state_ff == C_IDLE) && req_valid;
      cmd.mul1       = (state_ff == C_MUL1);
      cmd.mul2       = (state_ff == C_MUL2);
      cmd.sel_status = (state_ff == C_OUT_STATUS);
      cmd.clear      = (state_ff == C_OUT_STATUS) && rsp_ready;
   end

   // Status beat only follows a byte marked last
   a_status_needs_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_OUT_STATUS) |-> stat.pend_last)
      else $error("status beat without a last byte");

endmodule

### design/vcsp_dp.sv
// Parse datapath: byte decode, chunk counters, grid dims, index multiplier,
// pending result registers. Depends on vcsp_pkg; driven by vcsp_ctrl commands.
module vcsp_dp import vcsp_pkg::*; #(
   parameter logic [WORD_W-1:0] MAX_DIM = vcsp_pkg::MAX_DIM
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_stat_type       stat,
   input  logic [BYTE_W-1:0] req_byte,
   input  logic              req_last,
   output kind_type          rsp_kind,
   output logic [GI_W-1:0]   rsp_grid_index,
   output logic [WORD_W-1:0] rsp_color,
   output logic [SLOT_W-1:0] rsp_palette_index,
   output logic [DIM_W-1:0]  rsp_size_x,
   output logic [DIM_W-1:0]  rsp_size_y,
   output logic [DIM_W-1:0]  rsp_size_z,
   output logic              rsp_palette_seen,
   output logic              rsp_end_of_run
);

   // Parse state
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  fbc_ff, fbc_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] tag_ff, tag_in;
   logic [WORD_W-1:0] content_ff, content_in;
   logic [WORD_W-1:0] children_ff, children_in;
   logic [WORD_W-1:0] main_ff, main_in;
   logic [WORD_W-1:0] voxels_ff, voxels_in;
   logic [DIM_W-1:0]  dim_x_ff, dim_x_in;
   logic [DIM_W-1:0]  dim_y_ff, dim_y_in;
   logic [DIM_W-1:0]  dim_z_ff, dim_z_in;
   logic              grid_ff, grid_in;
   logic              pal_ff, pal_in;
   logic              err_ff, err_in;

   // Pending result
   logic              pend_par_ff, pend_par_in;
   logic              pend_last_ff;
   kind_type          pend_kind_ff, pend_kind_in;
   kind_type          pend_stat_ff, pend_stat_in;
   logic [WORD_W-1:0] pend_color_ff, pend_color_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [BYTE_W-1:0] pend_vx_ff, pend_vy_ff, pend_vz_ff;
   logic [MID_W-1:0]  mid_ff, mid_in;
   logic [GI_W-1:0]   gi_ff, gi_in;

   logic              short_hdr;
   logic              ok;
   logic              is_clear;
   logic [DIM_W-1:0]  m1_a, m1_b, m2_a;
   logic [BYTE_W-1:0] m1_add, m2_add;
   logic [2*DIM_W-1:0] m1_prod;
   logic [DIM_W+MID_W-1:0] m2_prod;

   // Decode one byte: next parse state and the result it causes
   always_comb begin
      phase_in      = phase_ff;
      fbc_in        = fbc_ff;
      word_in       = {req_byte, word_ff[WORD_W-1:BYTE_W]};
      tag_in        = tag_ff;
      content_in    = content_ff;
      children_in   = children_ff;
      main_in       = main_ff;
      voxels_in     = voxels_ff;
      dim_x_in      = dim_x_ff;
      dim_y_in      = dim_y_ff;
      dim_z_in      = dim_z_ff;
      grid_in       = grid_ff;
      pal_in        = pal_ff;
      err_in        = err_ff;
      pend_par_in   = 1'b0;
      pend_kind_in  = K_SIZES;
      pend_color_in = '0;
      pend_slot_in  = '0;

      case (phase_ff)
         PH_MAGIC: begin
            fbc_in = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               if (word_in != TAG_VOX) begin
                  err_in   = 1'b1;
                  phase_in = PH_DEAD;
               end else begin
                  phase_in = PH_VERSION;
                  fbc_in   = '0;
               end
            end
         end
         PH_VERSION: begin
            fbc_in = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               phase_in = PH_MAIN_ID;
               fbc_in   = '0;
            end
         end
         PH_MAIN_ID: begin
            fbc_in = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               if (word_in != TAG_MAIN) begin
                  err_in   = 1'b1;
                  phase_in = PH_DEAD;
               end else begin
                  phase_in = PH_MAIN_HDR;
                  fbc_in   = '0;
               end
            end
         end
         PH_MAIN_HDR: begin
            fbc_in = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               content_in = word_in;
            end
            if (fbc_in == 11'd8) begin
               main_in = word_in;
               if (content_in != '0) begin
                  phase_in = PH_MAIN_SKIP;
               end else begin
                  fbc_in   = '0;
                  phase_in = chunk_start(main_in);
               end
            end
         end
         PH_MAIN_SKIP: begin
            content_in = sat_dec(content_ff);
            if (content_in == '0) begin
               fbc_in   = '0;
               phase_in = chunk_start(main_in);
            end
         end
         PH_CHUNK_HDR: begin
            main_in = sat_dec(main_ff);
            fbc_in  = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               tag_in = word_in;
            end else if (fbc_in == 11'd8) begin
               content_in = word_in;
            end else if (fbc_in == 11'd12) begin
               children_in = word_in;
               fbc_in      = '0;
               if (tag_ff == TAG_SIZE && content_ff >= SIZE_BYTES) begin
                  phase_in = PH_SIZE;
               end else if (tag_ff == TAG_XYZI && content_ff >= XYZI_MIN) begin
                  phase_in = PH_XCOUNT;
               end else if (tag_ff == TAG_RGBA && content_ff >= PAL_BYTES) begin
                  phase_in = PH_RGBA;
               end else begin
                  phase_in = fin_content(content_in, children_in, main_in);
               end
            end
         end
         PH_SIZE: begin
            content_in = sat_dec(content_ff);
            main_in    = sat_dec(main_ff);
            fbc_in     = fbc_ff + 11'd1;
            if (fbc_in[1:0] == 2'd0) begin
               if (word_in > MAX_DIM) begin
                  err_in   = 1'b1;
                  phase_in = PH_DEAD;
               end else begin
                  case (fbc_in[3:2])
                     2'd1:    dim_x_in = word_in[DIM_W-1:0];
                     2'd2:    dim_y_in = word_in[DIM_W-1:0];
                     default: dim_z_in = word_in[DIM_W-1:0];
                  endcase
                  if (fbc_in == 11'd12) begin
                     pend_par_in  = 1'b1;
                     pend_kind_in = K_SIZES;
                     fbc_in       = '0;
                     phase_in     = fin_content(content_in, children_in, main_in);
                  end
               end
            end
         end
         PH_XCOUNT: begin
            content_in = sat_dec(content_ff);
            main_in    = sat_dec(main_ff);
            fbc_in     = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               voxels_in = (word_in < {2'b00, content_in[WORD_W-1:2]})
                           ? word_in : {2'b00, content_in[WORD_W-1:2]};
               grid_in      = (dim_x_ff != '0) && (dim_y_ff != '0) && (dim_z_ff != '0);
               pend_par_in  = 1'b1;
               pend_kind_in = K_CLEAR;
               fbc_in       = '0;
               if (voxels_in != '0) begin
                  phase_in = PH_XREC;
               end else begin
                  phase_in = fin_content(content_in, children_in, main_in);
               end
            end
         end
         PH_XREC: begin
            content_in = sat_dec(content_ff);
            main_in    = sat_dec(main_ff);
            fbc_in     = fbc_ff + 11'd1;
            if (fbc_in == 11'd4) begin
               fbc_in = '0;
               if ({1'b0, word_in[7:0]} < dim_x_ff && {1'b0, word_in[15:8]} < dim_y_ff &&
                   {1'b0, word_in[23:16]} < dim_z_ff && word_in[31:24] != '0) begin
                  pend_par_in   = 1'b1;
                  pend_kind_in  = K_WRITE;
                  pend_color_in = {24'd0, word_in[31:24]};
               end
               voxels_in = sat_dec(voxels_ff);
               if (voxels_in == '0) begin
                  phase_in = fin_content(content_in, children_in, main_in);
               end
            end
         end
         PH_RGBA: begin
            content_in = sat_dec(content_ff);
            main_in    = sat_dec(main_ff);
            fbc_in     = fbc_ff + 11'd1;
            if (fbc_in[1:0] == 2'd0) begin
               pend_par_in   = 1'b1;
               pend_kind_in  = K_PALETTE;
               pend_color_in = word_in;
               pend_slot_in  = fbc_in[SLOT_W+1:2] - 8'd1;
               if ({21'd0, fbc_in} >= PAL_BYTES) begin
                  pal_in   = 1'b1;
                  fbc_in   = '0;
                  phase_in = fin_content(content_in, children_in, main_in);
               end
            end
         end
         PH_SKIPC: begin
            content_in = sat_dec(content_ff);
            main_in    = sat_dec(main_ff);
            phase_in   = fin_content(content_in, children_in, main_in);
         end
         PH_SKIPK: begin
            children_in = sat_dec(children_ff);
            main_in     = sat_dec(main_ff);
            if (children_in == '0) begin
               fbc_in   = '0;
               phase_in = chunk_start(main_in);
            end
         end
         default: begin
         end
      endcase
   end

   // Final status from the state after this byte
   always_comb begin
      short_hdr    = phase_in inside {PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_HDR};
      ok           = !err_in && !short_hdr && (dim_x_in != '0) && grid_in;
      pend_stat_in = ok ? K_OK : K_ERROR;
   end

   // Status toward the controller
   always_comb begin
      stat.par       = pend_par_in;
      stat.mul       = pend_par_in && (pend_kind_in == K_CLEAR || pend_kind_in == K_WRITE);
      stat.last      = req_last;
      stat.pend_last = pend_last_ff;
   end

   // Update parse state on a byte; drop back to reset after the status beat
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         phase_ff    <= PH_MAGIC;
         fbc_ff      <= '0;
         word_ff     <= '0;
         tag_ff      <= '0;
         content_ff  <= '0;
         children_ff <= '0;
         main_ff     <= '0;
         voxels_ff   <= '0;
         dim_x_ff    <= '0;
         dim_y_ff    <= '0;
         dim_z_ff    <= '0;
         grid_ff     <= 1'b0;
         pal_ff      <= 1'b0;
         err_ff      <= 1'b0;
         pend_par_ff <= 1'b0;
         pend_last_ff <= 1'b0;
      end else if (cmd.step) begin
         phase_ff    <= phase_in;
         fbc_ff      <= fbc_in;
         word_ff     <= word_in;
         tag_ff      <= tag_in;
         content_ff  <= content_in;
         children_ff <= children_in;
         main_ff     <= main_in;
         voxels_ff   <= voxels_in;
         dim_x_ff    <= dim_x_in;
         dim_y_ff    <= dim_y_in;
         dim_z_ff    <= dim_z_in;
         grid_ff     <= grid_in;
         pal_ff      <= pal_in;
         err_ff      <= err_in;
         pend_par_ff <= pend_par_in;
         pend_last_ff <= req_last;
      end
   end

   // Hold the pending result payload
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pend_kind_ff  <= pend_kind_in;
         pend_stat_ff  <= pend_stat_in;
         pend_color_ff <= pend_color_in;
         pend_slot_ff  <= pend_slot_in;
         pend_vx_ff    <= word_in[7:0];
         pend_vy_ff    <= word_in[15:8];
         pend_vz_ff    <= word_in[23:16];
      end
   end

   // Multiplier operands: clear is x*y then *z, write is y + sy*z then x + sx*t
   always_comb begin
      is_clear = (pend_kind_ff == K_CLEAR);
      m1_a     = is_clear ? dim_x_ff : dim_y_ff;
      m1_b     = is_clear ? dim_y_ff : {1'b0, pend_vz_ff};
      m1_add   = is_clear ? '0 : pend_vy_ff;
      m2_a     = is_clear ? dim_z_ff : dim_x_ff;
      m2_add   = is_clear ? '0 : pend_vx_ff;
      m1_prod  = m1_a * m1_b;
      m2_prod  = m2_a * mid_ff;
      mid_in   = MID_W'(m1_prod + {10'd0, m1_add});
      gi_in    = GI_W'(m2_prod + {18'd0, m2_add});
   end

   // First pass into mid, second into the grid index; clear it on a new byte
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         mid_ff <= mid_in;
      end
      if (cmd.step) begin
         gi_ff <= '0;
      end else if (cmd.mul2) begin
         gi_ff <= gi_in;
      end
   end

   // Result beat payload
   always_comb begin
      rsp_kind          = cmd.sel_status ? pend_stat_ff : pend_kind_ff;
      rsp_grid_index    = cmd.sel_status ? '0 : gi_ff;
      rsp_color         = cmd.sel_status ? '0 : pend_color_ff;
      rsp_palette_index = cmd.sel_status ? '0 : pend_slot_ff;
      rsp_size_x        = dim_x_ff;
      rsp_size_y        = dim_y_ff;
      rsp_size_z        = dim_z_ff;
      rsp_palette_seen  = pal_ff;
      rsp_end_of_run    = cmd.sel_status || !pend_last_ff;
   end

   // An error parks the parser until the file ends
   a_err_dead: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (phase_ff == PH_DEAD))
      else $error("error flag set outside the dead phase");

   // A voxel write only follows a grid clear with a nonzero cell count
   a_write_grid: assert property (@(posedge clock) disable iff (reset)
      (pend_par_ff && pend_kind_ff == K_WRITE) |-> grid_ff)
      else $error("voxel write without a grid");

   // The last palette slot marks the palette as seen
   a_pal_seen: assert property (@(posedge clock) disable iff (reset)
      (pend_par_ff && pend_kind_ff == K_PALETTE && pend_slot_ff == 8'hFF) |-> pal_ff)
      else $error("last palette slot without palette flag");

endmodule

### sim/tb.sv
// Self-checking bench for the voxel chunk stream parser: file bytes in, parse beats out.
// Depends on vcsp_pkg, the vcsp_req_if/vcsp_rsp_if channels and vox_chunk_stream_parser_unit.
module tb;
   import vcsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 850;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_AFTER   = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 10;

   typedef logic [BYTE_W-1:0] byte_q_type [$];

   typedef struct packed {
      kind_type          kind;
      logic [GI_W-1:0]   grid_index;
      logic [WORD_W-1:0] color;
      logic [SLOT_W-1:0] palette_index;
      logic [DIM_W-1:0]  size_x;
      logic [DIM_W-1:0]  size_y;
      logic [DIM_W-1:0]  size_z;
      logic              palette_seen;
      logic              end_of_run;
   } parse_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] b;
      logic              l;
      logic              typed;
   } byte_row_type;

   typedef enum int {CH_SIZE, CH_XYZI, CH_RGBA, CH_OTHER} chunk_pick_type;

   logic clock = 1'b0;
   logic reset;

   vcsp_req_if req_if ();
   vcsp_rsp_if rsp_if ();

   vox_chunk_stream_parser_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Parser state mirrored by the predictor
   phase_type         ps_phase;
   logic [CNT_W-1:0]  ps_count;
   logic [WORD_W-1:0] ps_word, ps_tag, ps_content, ps_children, ps_main, ps_voxels;
   logic [DIM_W-1:0]  ps_dims [3];
   logic              ps_grid, ps_palette, ps_error;

   parse_result_type step_results [$];
   parse_result_type awaited_results [$];
   byte_q_type       file_bytes;
   int unsigned      gen_dim [3];

   int  mismatches   = 0;
   int  results_seen = 0;
   int  live_bytes   = 0;
   int  idle_cycles  = 0;
   bit  hold_done    = 1'b0;
   bit  tx_steady    = 1'b0;

   // Directed rows: short headers, bad magic, bad MAIN id, byte extremes
   byte_row_type directed_rows [0:19] = '{
      '{8'h56, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1},
      '{8'h56, 1'b0, 1'b0}, '{8'h4F, 1'b0, 1'b0}, '{8'h58, 1'b0, 1'b0}, '{8'h20, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'h4D, 1'b0, 1'b0}, '{8'h41, 1'b0, 1'b0}, '{8'h49, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   task automatic clear_parser();
      ps_phase    = PH_MAGIC;
      ps_count    = '0;
      ps_word     = '0;
      ps_tag      = '0;
      ps_content  = '0;
      ps_children = '0;
      ps_main     = '0;
      ps_voxels   = '0;
      ps_dims     = '{default: '0};
      ps_grid     = 1'b0;
      ps_palette  = 1'b0;
      ps_error    = 1'b0;
   endtask

   task automatic add_result(input kind_type k, input logic [GI_W-1:0] gi,
                             input logic [WORD_W-1:0] col, input logic [SLOT_W-1:0] slot);
      parse_result_type r;
      r.kind          = k;
      r.grid_index    = gi;
      r.color         = col;
      r.palette_index = slot;
      r.size_x        = ps_dims[0];
      r.size_y        = ps_dims[1];
      r.size_z        = ps_dims[2];
      r.palette_seen  = ps_palette;
      r.end_of_run    = 1'b0;
      step_results.push_back(r);
   endtask

   task automatic parse_fault();
      ps_error = 1'b1;
      ps_phase = PH_DEAD;
   endtask

   task automatic take_region_byte();
      if (ps_main != 0) ps_main = ps_main - 1;
   endtask

   task automatic take_content_byte();
      if (ps_content != 0) ps_content = ps_content - 1;
      take_region_byte();
   endtask

   // Start the next child if a whole header still fits in the MAIN region
   task automatic open_next_chunk();
      ps_count = '0;
      ps_phase = (ps_main >= HDR_BYTES) ? PH_CHUNK_HDR : PH_DONE;
   endtask

   // Skip leftover content, then sub-chunks, then move on
   task automatic close_content();
      if (ps_content != 0) begin
         ps_phase = PH_SKIPC;
      end else if (ps_children != 0) begin
         ps_phase = PH_SKIPK;
      end else begin
         open_next_chunk();
      end
   endtask

   // Advance the parser by one file byte and collect the beats it causes
   task automatic parse_file_byte(input logic [BYTE_W-1:0] b, input logic l);
      logic [WORD_W-1:0] avail, cells, vx, vy, vz, ci, idx;
      logic              short_hdr, ok;
      step_results.delete();
      ps_word = {b, ps_word[WORD_W-1:8]};
      case (ps_phase)
         PH_MAGIC: begin
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               if (ps_word != TAG_VOX) begin
                  parse_fault();
               end else begin
                  ps_phase = PH_VERSION;
                  ps_count = '0;
               end
            end
         end
         PH_VERSION: begin
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               ps_phase = PH_MAIN_ID;
               ps_count = '0;
            end
         end
         PH_MAIN_ID: begin
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               if (ps_word != TAG_MAIN) begin
                  parse_fault();
               end else begin
                  ps_phase = PH_MAIN_HDR;
                  ps_count = '0;
               end
            end
         end
         PH_MAIN_HDR: begin
            ps_count = ps_count + 1;
            if (ps_count == 4) ps_content = ps_word;
            if (ps_count == 8) begin
               ps_main = ps_word;
               if (ps_content != 0) ps_phase = PH_MAIN_SKIP;
               else open_next_chunk();
            end
         end
         PH_MAIN_SKIP: begin
            if (ps_content != 0) ps_content = ps_content - 1;
            if (ps_content == 0) open_next_chunk();
         end
         PH_CHUNK_HDR: begin
            take_region_byte();
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               ps_tag = ps_word;
            end else if (ps_count == 8) begin
               ps_content = ps_word;
            end else if (ps_count == 12) begin
               ps_children = ps_word;
               ps_count    = '0;
               if (ps_tag == TAG_SIZE && ps_content >= SIZE_BYTES) ps_phase = PH_SIZE;
               else if (ps_tag == TAG_XYZI && ps_content >= XYZI_MIN) ps_phase = PH_XCOUNT;
               else if (ps_tag == TAG_RGBA && ps_content >= PAL_BYTES) ps_phase = PH_RGBA;
               else close_content();
            end
         end
         PH_SIZE: begin
            take_content_byte();
            ps_count = ps_count + 1;
            if (ps_count[1:0] == 2'b00) begin
               if (ps_word > MAX_DIM) begin
                  parse_fault();
               end else begin
                  ps_dims[(ps_count >> 2) - 1] = ps_word[DIM_W-1:0];
                  if (ps_count == 12) begin
                     add_result(K_SIZES, '0, '0, '0);
                     close_content();
                  end
               end
            end
         end
         PH_XCOUNT: begin
            take_content_byte();
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               avail     = ps_content / 4;
               cells     = 32'(ps_dims[0]) * 32'(ps_dims[1]) * 32'(ps_dims[2]);
               ps_voxels = (ps_word < avail) ? ps_word : avail;
               ps_grid   = (cells != 0);
               add_result(K_CLEAR, cells[GI_W-1:0], '0, '0);
               ps_count  = '0;
               if (ps_voxels != 0) ps_phase = PH_XREC;
               else close_content();
            end
         end
         PH_XREC: begin
            take_content_byte();
            ps_count = ps_count + 1;
            if (ps_count == 4) begin
               vx       = 32'(ps_word[7:0]);
               vy       = 32'(ps_word[15:8]);
               vz       = 32'(ps_word[23:16]);
               ci       = 32'(ps_word[31:24]);
               ps_count = '0;
               if (vx < 32'(ps_dims[0]) && vy < 32'(ps_dims[1]) && vz < 32'(ps_dims[2])
                   && ci != 0) begin
                  idx = vx + 32'(ps_dims[0]) * (vy + 32'(ps_dims[1]) * vz);
                  add_result(K_WRITE, idx[GI_W-1:0], ci, '0);
               end
               if (ps_voxels != 0) ps_voxels = ps_voxels - 1;
               if (ps_voxels == 0) close_content();
            end
         end
         PH_RGBA: begin
            take_content_byte();
            ps_count = ps_count + 1;
            if (ps_count[1:0] == 2'b00) begin
               if (32'(ps_count) >= PAL_BYTES) ps_palette = 1'b1;
               add_result(K_PALETTE, '0, ps_word, SLOT_W'((ps_count >> 2) - 1));
               if (32'(ps_count) >= PAL_BYTES) close_content();
            end
         end
         PH_SKIPC: begin
            take_content_byte();
            close_content();
         end
         PH_SKIPK: begin
            if (ps_children != 0) ps_children = ps_children - 1;
            take_region_byte();
            if (ps_children == 0) open_next_chunk();
         end
         default: begin
         end
      endcase

      // Final byte: report status, then start over for the next file
      if (l) begin
         short_hdr = (ps_phase == PH_MAGIC) || (ps_phase == PH_VERSION) ||
                     (ps_phase == PH_MAIN_ID) || (ps_phase == PH_MAIN_HDR);
         ok = !ps_error && !short_hdr && (ps_dims[0] != 0) && ps_grid;
         add_result(ok ? K_OK : K_ERROR, '0, '0, '0);
         clear_parser();
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].end_of_run = 1'b1;
   endtask

   // ---------------------------------------------------------------- file builder
   task automatic push_word(ref byte_q_type q, input logic [WORD_W-1:0] w);
      int k;
      for (k = 0; k < 4; k++) q.push_back(w[8*k +: 8]);
   endtask

   // Header, content and raw sub-chunk bytes of one chunk
   task automatic append_chunk(ref byte_q_type q, input logic [WORD_W-1:0] tag,
                               ref byte_q_type body);
      int kids_n;
      kids_n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
      push_word(q, tag);
      push_word(q, body.size());
      push_word(q, kids_n);
      foreach (body[i]) q.push_back(body[i]);
      repeat (kids_n) q.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic build_chunk(ref byte_q_type q, input chunk_pick_type which,
                              input bit full_palette);
      byte_q_type        body;
      int                r, r2, n, declared, k, j;
      logic [WORD_W-1:0] w, rec;
      r = $urandom_range(0, 99);
      case (which)
         CH_SIZE: begin
            if (r < 8) begin
               // too short to count as a SIZE body
               repeat ($urandom_range(0, 11)) body.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
               for (k = 0; k < 3; k++) begin
                  r2 = $urandom_range(0, 99);
                  if (r2 < 70) w = $urandom_range(1, 6);
                  else if (r2 < 78) w = 0;
                  else if (r2 < 86) w = 256;
                  else if (r2 < 94) w = $urandom_range(250, 257);
                  else w = $urandom;
                  if (w <= MAX_DIM) gen_dim[k] = w;
                  push_word(body, w);
               end
               if (r >= 90) repeat ($urandom_range(1, 3))
                  body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            append_chunk(q, TAG_SIZE, body);
         end
         CH_XYZI: begin
            if (r < 5) begin
               repeat ($urandom_range(0, 3)) body.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
               declared = n;
               if (r < 20) declared = n + $urandom_range(1, 5);
               else if (r < 30 && n > 0) declared = $urandom_range(0, n - 1);
               push_word(body, declared);
               for (j = 0; j < n; j++) begin
                  // mostly inside the grid, some stray coordinates and blank colours
                  for (k = 0; k < 3; k++) begin
                     if (gen_dim[k] > 0 && gen_dim[k] <= 256 && $urandom_range(0, 9) != 0)
                        rec[8*k +: 8] = BYTE_W'($urandom_range(0, gen_dim[k] - 1));
                     else
                        rec[8*k +: 8] = BYTE_W'($urandom_range(0, 255));
                  end
                  rec[31:24] = ($urandom_range(0, 6) == 0) ? 8'h00
                                                          : BYTE_W'($urandom_range(1, 255));
                  push_word(body, rec);
               end
               if (r >= 92) repeat ($urandom_range(1, 3))
                  body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            append_chunk(q, TAG_XYZI, body);
         end
         CH_RGBA: begin
            if (full_palette) begin
               repeat (256) push_word(body, $urandom);
            end else begin
               repeat ($urandom_range(0, 16)) body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            append_chunk(q, TAG_RGBA, body);
         end
         default: begin
            repeat ($urandom_range(0, 12)) body.push_back(BYTE_W'($urandom_range(0, 255)));
            append_chunk(q, $urandom, body);
         end
      endcase
   endtask

   // One voxel file: mostly well formed, some noise, bad tags, odd regions, truncation
   task automatic build_file(input bit full_palette);
      byte_q_type        kids;
      int                r, r2, k, n, cut;
      logic [WORD_W-1:0] w, mcont, kids_len;
      file_bytes.delete();
      gen_dim = '{0, 0, 0};
      r = $urandom_range(0, 99);
      if (r < 6 && !full_palette) begin
         repeat ($urandom_range(1, 24)) file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end else begin
         w = TAG_VOX;
         if (r < 10 && !full_palette) begin
            k = $urandom_range(0, 31);
            w[k] = ~w[k];
         end
         push_word(file_bytes, w);
         push_word(file_bytes, $urandom);
         w = TAG_MAIN;
         if (r >= 10 && r < 14 && !full_palette) begin
            k = $urandom_range(0, 31);
            w[k] = ~w[k];
         end
         push_word(file_bytes, w);

         // Child chunks
         if (r < 80 || full_palette) begin
            build_chunk(kids, CH_SIZE, 1'b0);
            build_chunk(kids, CH_XYZI, 1'b0);
            n = $urandom_range(0, 2);
         end else begin
            n = $urandom_range(1, 5);
         end
         repeat (n) build_chunk(kids, chunk_pick_type'($urandom_range(0, 3)), 1'b0);
         if (full_palette) build_chunk(kids, CH_RGBA, 1'b1);

         mcont    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         kids_len = kids.size();
         r2       = $urandom_range(0, 99);
         if (full_palette) r2 = 50;
         if (r2 < 10) kids_len = (kids_len > 16) ? kids_len - $urandom_range(1, 16) : 0;
         else if (r2 < 18) kids_len = kids_len + $urandom_range(1, 24);
         push_word(file_bytes, mcont);
         push_word(file_bytes, kids_len);
         repeat (mcont) file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         foreach (kids[i]) file_bytes.push_back(kids[i]);
         if (r2 >= 90 && r2 < 96) repeat ($urandom_range(1, 8))
            file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0 && !full_palette) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   // ---------------------------------------------------------------- pacing and checking
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic string fmt_result(parse_result_type r);
      return $sformatf("kind=%0d index=%0d color=%h slot=%0d size=%0d/%0d/%0d pal=%0b end=%0b",
                       r.kind, r.grid_index, r.color, r.palette_index,
                       r.size_x, r.size_y, r.size_z, r.palette_seen, r.end_of_run);
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
   endtask

   // Offer one byte, hold it until taken, then predict its beats
   task automatic put_byte(input logic [BYTE_W-1:0] b, input logic l, input logic typed);
      int               gap;
      parse_result_type err_beat;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.byte_req <= b;
      req_if.last     <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (ps_phase != PH_DEAD && ps_phase != PH_DONE && ps_phase != PH_RGBA) live_bytes++;
      parse_file_byte(b, l);
      if (typed) begin
         err_beat            = '0;
         err_beat.kind       = K_ERROR;
         err_beat.end_of_run = 1'b1;
         awaited_results.push_back(err_beat);
      end else begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
   endtask

   // Compare each taken result beat with the oldest one awaited
   always @(posedge clock) begin
      parse_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         got.kind          = rsp_if.kind;
         got.grid_index    = rsp_if.grid_index;
         got.color         = rsp_if.color;
         got.palette_index = rsp_if.palette_index;
         got.size_x        = rsp_if.size_x;
         got.size_y        = rsp_if.size_y;
         got.size_z        = rsp_if.size_z;
         got.palette_seen  = rsp_if.palette_seen;
         got.end_of_run    = rsp_if.end_of_run;
         if (awaited_results.size() == 0) begin
            log_mismatch($sformatf("unexpected beat: %s", fmt_result(got)));
         end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.grid_index !== want.grid_index ||
                got.color !== want.color || got.palette_index !== want.palette_index ||
                got.size_x !== want.size_x || got.size_y !== want.size_y ||
                got.size_z !== want.size_z || got.palette_seen !== want.palette_seen ||
                got.end_of_run !== want.end_of_run)
               log_mismatch($sformatf("expected %s, got %s", fmt_result(want),
                                      fmt_result(got)));
         end
      end
   end

   // End the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off so the parser backs up
   initial begin : rsp_pacing
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6))
            @(posedge clock);
      end
   end

   // Sender: reset, directed rows, then random files
   initial begin : req_stimulus
      bit first;
      clear_parser();
      req_if.valid    <= 1'b0;
      req_if.byte_req <= '0;
      req_if.last     <= 1'b0;
      reset           <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         put_byte(directed_rows[i].b, directed_rows[i].l, directed_rows[i].typed);

      first = 1'b1;
      while (live_bytes < RANDOM_ITEMS) begin
         build_file(first);
         first     = 1'b0;
         tx_steady = ($urandom_range(0, 3) == 0);
         foreach (file_bytes[i]) put_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0);
      end
      req_if.valid <= 1'b0;

      // Drain the result channel, then allow for pipeline latency
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### vox_chunk_stream_parser_unit.f
design/vcsp_pkg.sv
design/vcsp_if.sv
design/vcsp_ctrl.sv
design/vcsp_dp.sv
design/vox_chunk_stream_parser_unit.sv
sim/tb.sv
